@@ rtl/core/tgc_pkg.sv @@
// Shared types and constants for the touch gesture classifier.
package tgc_pkg;

  localparam int unsigned ReadingW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgW-1:0] ThresholdRst  = CfgW'(60);
  localparam logic [CfgW-1:0] TapWindowRst  = CfgW'(350);
  localparam logic [CfgW-1:0] LongPressRst  = CfgW'(600);
  localparam logic [CfgW-1:0] FullHoldRst   = CfgW'(2000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgTapWindow = 2'd1,
    CfgLongPress = 2'd2,
    CfgFullHold  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] touch_threshold;
    logic [CfgW-1:0] tap_window_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] full_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic press_started;
    logic long_press_began;
    logic long_press_held;
    logic single_tap;
    logic double_tap;
    logic long_released;
    logic full_hold;
  } result_t;

endpackage

@@ rtl/core/touch_gesture_classifier_unit.sv @@
// Result path: an accepted sample is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the output is not stalled; the classification logic between the two
// registers updates gesture state once per item, so items flow back to back.
// Reset: rst_ni async active low clears gesture state, both valid flags and
// loads the register defaults (threshold 60, window 350, long 600, full 2000).
module touch_gesture_classifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tgc_pkg::ReadingW-1:0]  sensor_reading_i,
  input  logic [tgc_pkg::TimeW-1:0]     now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          press_started_o,
  output logic                          long_press_began_o,
  output logic                          long_press_held_o,
  output logic                          single_tap_o,
  output logic                          double_tap_o,
  output logic                          long_released_o,
  output logic                          full_hold_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgc_pkg::CfgW-1:0]      cfg_data_i
);
  import tgc_pkg::*;

  logic                in_v_q;
  logic [ReadingW-1:0] reading_q;
  logic [TimeW-1:0]    now_q;
  logic                out_v_q;
  result_t             res_q;
  result_t             res;
  cfg_t                cfg;
  logic                advance;
  logic                in_take;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o  = in_v_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;

  tgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tgc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .cfg_i     (cfg),
    .reading_i (reading_q),
    .now_i     (now_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take)      in_v_q <= 1'b1;
      else if (advance) in_v_q <= 1'b0;
      if (advance)          out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      reading_q <= sensor_reading_i;
      now_q     <= now_ms_i;
    end
    if (advance) res_q <= res;
  end

  assign out_valid_o        = out_v_q;
  assign press_started_o    = res_q.press_started;
  assign long_press_began_o = res_q.long_press_began;
  assign long_press_held_o  = res_q.long_press_held;
  assign single_tap_o       = res_q.single_tap;
  assign double_tap_o       = res_q.double_tap;
  assign long_released_o    = res_q.long_released;
  assign full_hold_o        = res_q.full_hold;

`ifndef SYNTHESIS
  a_full_needs_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_hold_o |-> long_released_o)
    else $error("full_hold without long_released");

  a_tap_kinds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(single_tap_o && double_tap_o))
    else $error("single and double tap together");

  a_began_implies_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && long_press_began_o |-> long_press_held_o && !press_started_o)
    else $error("long press began without being held");

  a_stalled_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && in_v_q |-> in_stall_o)
    else $error("input taken while both stages are blocked");
`endif

endmodule

@@ rtl/core/tgc_cfg.sv @@
// Configuration register file for the touch gesture classifier.
module tgc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tgc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgc_pkg::CfgW-1:0]     cfg_data_i,
  output tgc_pkg::cfg_t                cfg_o
);
  import tgc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_threshold <= ThresholdRst;
      cfg_q.tap_window_ms   <= TapWindowRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.full_hold_ms    <= FullHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: cfg_q.touch_threshold <= cfg_data_i;
        CfgTapWindow: cfg_q.tap_window_ms   <= cfg_data_i;
        CfgLongPress: cfg_q.long_press_ms   <= cfg_data_i;
        CfgFullHold:  cfg_q.full_hold_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/tgc_core.sv @@
// Gesture state and per-sample classification logic.
module tgc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  tgc_pkg::cfg_t                 cfg_i,
  input  logic [tgc_pkg::ReadingW-1:0]  reading_i,
  input  logic [tgc_pkg::TimeW-1:0]     now_i,
  output tgc_pkg::result_t              res_o
);
  import tgc_pkg::*;

  logic             touch_active_q, touch_active_d;
  logic             long_active_q, long_active_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] last_tap_q, last_tap_d;
  logic [1:0]       tap_count_q, tap_count_d;

  logic             touched;
  logic [TimeW-1:0] held_ms;
  logic [TimeW-1:0] quiet_ms;
  result_t          res;

  always_comb begin
    touch_active_d = touch_active_q;
    long_active_d  = long_active_q;
    press_time_d   = press_time_q;
    last_tap_d     = last_tap_q;
    tap_count_d    = tap_count_q;
    res            = '0;

    touched = ReadingW'(reading_i) < cfg_i.touch_threshold;

    // rise
    if (touched && !touch_active_q) begin
      touch_active_d    = 1'b1;
      press_time_d      = now_i;
      res.press_started = 1'b1;
    end

    // hold time against the (possibly just latched) press start
    held_ms = now_i - press_time_d;

    if (touched && !long_active_q &&
        held_ms > {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms}) begin
      long_active_d        = 1'b1;
      tap_count_d          = 2'd0;
      res.long_press_began = 1'b1;
    end

    // fall
    if (!touched && touch_active_q) begin
      touch_active_d = 1'b0;
      if (long_active_q) begin
        long_active_d     = 1'b0;
        res.long_released = 1'b1;
        res.full_hold     = held_ms > {{(TimeW-CfgW){1'b0}}, cfg_i.full_hold_ms};
      end else begin
        if (tap_count_q != 2'd2) tap_count_d = tap_count_q + 2'd1;
        last_tap_d = now_i;
      end
    end

    // tap window timeout
    quiet_ms = now_i - last_tap_d;
    if (!touched && !long_active_d && tap_count_d != 2'd0 &&
        quiet_ms > {{(TimeW-CfgW){1'b0}}, cfg_i.tap_window_ms}) begin
      if (tap_count_d == 2'd1) res.single_tap = 1'b1;
      else                     res.double_tap = 1'b1;
      tap_count_d = 2'd0;
    end

    res.long_press_held = long_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_active_q <= 1'b0;
      long_active_q  <= 1'b0;
      press_time_q   <= '0;
      last_tap_q     <= '0;
      tap_count_q    <= 2'd0;
    end else if (step_i) begin
      touch_active_q <= touch_active_d;
      long_active_q  <= long_active_d;
      press_time_q   <= press_time_d;
      last_tap_q     <= last_tap_d;
      tap_count_q    <= tap_count_d;
    end
  end

  assign res_o = res;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the touch gesture classifier unit.
`timescale 1ns / 100ps

module testbench;
  import tgc_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned IdleGap       = 4;
  localparam int unsigned DrainLimit    = 2000;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned PhaseItems    = 100;

  typedef enum {
    GestTap,
    GestMultiTap,
    GestLong,
    GestBoundary,
    GestNoise,
    GestQuiet
  } gesture_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ReadingW-1:0] sensor_reading_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                press_started_o;
  logic                long_press_began_o;
  logic                long_press_held_o;
  logic                single_tap_o;
  logic                double_tap_o;
  logic                long_released_o;
  logic                full_hold_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  touch_gesture_classifier_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sensor_reading_i   (sensor_reading_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .press_started_o    (press_started_o),
    .long_press_began_o (long_press_began_o),
    .long_press_held_o  (long_press_held_o),
    .single_tap_o       (single_tap_o),
    .double_tap_o       (double_tap_o),
    .long_released_o    (long_released_o),
    .full_hold_o        (full_hold_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Mirror of the registers and of the gesture tracker.
  cfg_t            cfg_mirror;
  logic            pad_down;
  logic            long_hold;
  logic [TimeW-1:0] press_start_ms;
  logic [TimeW-1:0] last_tap_ms;
  logic [1:0]      pending_taps;

  result_t         pending_gestures[$];
  result_t         want;
  logic [TimeW-1:0] clock_ms;

  int unsigned fail_count;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned singles_seen;
  int unsigned doubles_seen;
  int unsigned longs_seen;
  int unsigned full_holds_seen;
  int unsigned cycle_count;

  bit          pace_on;
  bit          stall_on;
  int unsigned burst_left;
  int unsigned holdoff_req;
  int unsigned holdoff_left;
  int unsigned stall_run;
  bit          stall_phase;

  function automatic result_t classify_sample(input logic [ReadingW-1:0] reading,
                                              input logic [TimeW-1:0] stamp);
    result_t          r;
    logic             touched;
    logic [TimeW-1:0] elapsed;
    r = '0;
    touched = reading < cfg_mirror.touch_threshold;
    if (touched && !pad_down) begin
      pad_down = 1'b1;
      press_start_ms = stamp;
      r.press_started = 1'b1;
    end
    if (touched && pad_down && !long_hold) begin
      elapsed = stamp - press_start_ms;
      if (elapsed > TimeW'(cfg_mirror.long_press_ms)) begin
        long_hold = 1'b1;
        pending_taps = 2'd0;
        r.long_press_began = 1'b1;
      end
    end
    if (!touched && pad_down) begin
      pad_down = 1'b0;
      if (long_hold) begin
        long_hold = 1'b0;
        elapsed = stamp - press_start_ms;
        r.long_released = 1'b1;
        r.full_hold = elapsed > TimeW'(cfg_mirror.full_hold_ms);
      end else begin
        if (pending_taps < 2'd2) pending_taps = pending_taps + 2'd1;
        last_tap_ms = stamp;
      end
    end
    // taps settle only once the pad has been quiet for longer than the window
    if (!touched && !long_hold && pending_taps != 2'd0) begin
      elapsed = stamp - last_tap_ms;
      if (elapsed > TimeW'(cfg_mirror.tap_window_ms)) begin
        if (pending_taps == 2'd1) r.single_tap = 1'b1;
        else r.double_tap = 1'b1;
        pending_taps = 2'd0;
      end
    end
    r.long_press_held = long_hold;
    return r;
  endfunction

  function automatic void check_flag(input string field, input logic exp, input logic act);
    if (act !== exp) begin
      $error("%s: expected %0b, got %0b", field, exp, act);
      fail_count++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", CycleLimit);
    $display("touch_gesture_classifier_unit verification failed");
    $finish;
  end

  // Receiver: random stall pattern, plus a long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req = 0;
      end
      if (holdoff_left != 0) begin
        out_stall_i = 1'b1;
        holdoff_left--;
      end else if (!stall_on) begin
        out_stall_i = 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_phase = !stall_phase;
          stall_run = stall_phase ? $urandom_range(5, 1) : $urandom_range(9, 1);
        end
        stall_run--;
        out_stall_i = stall_phase;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_gestures.size() == 0) begin
        $error("result arrived with no sample outstanding");
        fail_count++;
      end else begin
        want = pending_gestures.pop_front();
        check_flag("press_started", want.press_started, press_started_o);
        check_flag("long_press_began", want.long_press_began, long_press_began_o);
        check_flag("long_press_held", want.long_press_held, long_press_held_o);
        check_flag("single_tap", want.single_tap, single_tap_o);
        check_flag("double_tap", want.double_tap, double_tap_o);
        check_flag("long_released", want.long_released, long_released_o);
        check_flag("full_hold", want.full_hold, full_hold_o);
        results_checked++;
        singles_seen += want.single_tap;
        doubles_seen += want.double_tap;
        longs_seen += want.long_press_began;
        full_holds_seen += want.full_hold;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_sample(input logic [ReadingW-1:0] reading, input logic [TimeW-1:0] stamp);
    in_valid_i = 1'b1;
    sensor_reading_i = reading;
    now_ms_i = stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_gestures.push_back(classify_sample(reading, stamp));
    samples_sent++;
    @(negedge clk_i);
    if (pace_on) begin
      if (burst_left == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(8, 1)) @(negedge clk_i);
        burst_left = $urandom_range(12, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic put_sample(input bit touch, input int unsigned dt);
    logic [ReadingW-1:0] reading;
    clock_ms = clock_ms + dt;
    if (touch && cfg_mirror.touch_threshold != '0)
      reading = ReadingW'($urandom_range(cfg_mirror.touch_threshold - 1, 0));
    else
      reading = ReadingW'($urandom_range(16'hFFFF, cfg_mirror.touch_threshold));
    send_sample(reading, clock_ms);
  endtask

  // One press: first touched sample after lead, n touched samples, then release at dur.
  task automatic hold_touch(input int unsigned lead, input int unsigned dur, input int unsigned n);
    int unsigned step;
    step = dur / n;
    put_sample(1'b1, lead);
    for (int unsigned i = 1; i < n; i++) put_sample(1'b1, step);
    put_sample(1'b0, dur - step * (n - 1));
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_gestures.size() != 0) @(negedge clk_i);
    repeat (IdleGap) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgThreshold: cfg_mirror.touch_threshold = value;
      CfgTapWindow: cfg_mirror.tap_window_ms = value;
      CfgLongPress: cfg_mirror.long_press_ms = value;
      CfgFullHold:  cfg_mirror.full_hold_ms = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_settings(input logic [CfgW-1:0] thr, input logic [CfgW-1:0] win,
                                input logic [CfgW-1:0] lp, input logic [CfgW-1:0] fh);
    wait_idle();
    write_register(CfgThreshold, thr);
    write_register(CfgTapWindow, win);
    write_register(CfgLongPress, lp);
    write_register(CfgFullHold, fh);
  endtask

  task automatic run_gesture();
    gesture_e    kind;
    int unsigned draw;
    int unsigned win;
    int unsigned lp;
    int unsigned fh;
    win = cfg_mirror.tap_window_ms;
    lp = cfg_mirror.long_press_ms;
    fh = cfg_mirror.full_hold_ms;
    draw = $urandom_range(9, 0);
    kind = draw < 3 ? GestTap : draw < 5 ? GestMultiTap : draw < 7 ? GestLong :
           draw == 7 ? GestBoundary : draw == 8 ? GestNoise : GestQuiet;
    case (kind)
      GestTap: begin
        hold_touch($urandom_range(40, 0), $urandom_range(lp, 0), $urandom_range(3, 1));
        put_sample(1'b0, $urandom_range(win + win / 4 + 2, 0));
      end
      GestMultiTap: begin
        repeat ($urandom_range(3, 2))
          hold_touch($urandom_range(win, 0), $urandom_range(lp, 0), $urandom_range(2, 1));
        put_sample(1'b0, $urandom_range(win + win / 2 + 2, win));
      end
      GestLong: begin
        hold_touch($urandom_range(40, 0), $urandom_range(fh + fh / 2 + 2, lp + 1),
                   $urandom_range(4, 2));
      end
      GestBoundary: begin
        // hold right at the long-press limit, release near the full-hold limit
        put_sample(1'b1, $urandom_range(40, 0));
        put_sample(1'b1, lp + $urandom_range(1, 0));
        put_sample(1'b0, (fh > lp ? fh - lp : 0) + $urandom_range(1, 0));
        put_sample(1'b0, win + $urandom_range(1, 0));
      end
      GestNoise: begin
        // arbitrary readings and time jumps, backwards ones included
        repeat ($urandom_range(3, 1)) begin
          clock_ms = clock_ms + $urandom;
          send_sample(ReadingW'($urandom_range(16'hFFFF, 0)), clock_ms);
        end
      end
      default: put_sample(1'b0, $urandom_range(2 * win + 2, 0));
    endcase
  endtask

  task automatic test_basic_gestures();
    // single tap; reading equal to the threshold is not a touch
    send_sample(16'hFFFF, 32'd1000);
    send_sample(16'd0, 32'd1010);
    send_sample(16'd59, 32'd1100);
    send_sample(16'd60, 32'd1150);
    send_sample(16'd1000, 32'd1500);  // exactly the window: not settled yet
    send_sample(16'd1000, 32'd1501);
    // three quick taps saturate to a double tap
    send_sample(16'd10, 32'd2000);
    send_sample(16'd100, 32'd2010);
    send_sample(16'd10, 32'd2020);
    send_sample(16'd100, 32'd2030);
    send_sample(16'd10, 32'd2040);
    send_sample(16'd100, 32'd2050);
    send_sample(16'd100, 32'd2401);
    // long press released early, then one held past full hold
    send_sample(16'd5, 32'd4000);
    send_sample(16'd5, 32'd4601);
    send_sample(16'd100, 32'd4700);
    send_sample(16'd5, 32'd5000);
    send_sample(16'd5, 32'd5601);
    send_sample(16'd100, 32'd7001);
  endtask

  task automatic test_time_wrap();
    // timestamp stepping back reads as a huge hold
    send_sample(16'd5, 32'd8000);
    send_sample(16'd5, 32'd7990);
    send_sample(16'd100, 32'd7995);
    // tap straddling the 32-bit rollover
    send_sample(16'd5, 32'hFFFF_FF00);
    send_sample(16'd5, 32'h0000_0010);
    send_sample(16'd100, 32'h0000_0020);
    send_sample(16'd100, 32'h0000_0020 + 32'd351);
  endtask

  task automatic test_register_extremes();
    apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd0);
    // zero long-press time still needs a second touched sample
    send_sample(16'hFFFE, 32'd100);
    send_sample(16'd0, 32'd101);
    send_sample(16'hFFFF, 32'd102);
    // zero window: tap settles on the next quiet sample, not its own release
    send_sample(16'hFFFE, 32'd200);
    send_sample(16'hFFFF, 32'd201);
    send_sample(16'hFFFF, 32'd202);
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'd0, 32'd300);
  endtask

  task automatic test_random_gestures();
    int unsigned phase_start;
    clock_ms = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_settings(ThresholdRst, TapWindowRst, LongPressRst, FullHoldRst);
        1: apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd0);
        2: apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: apply_settings(CfgW'($urandom_range(16'hFFFF, 1)), CfgW'($urandom_range(600, 0)),
                                CfgW'($urandom_range(800, 0)), CfgW'($urandom_range(3000, 0)));
      endcase
      phase_start = samples_sent;
      while (samples_sent - phase_start < PhaseItems) begin
        pace_on = $urandom_range(3, 0) != 0;
        stall_on = $urandom_range(3, 0) != 0;
        run_gesture();
      end
    end
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    int unsigned start;
    wait_idle();
    pace_on = 1'b0;
    stall_on = 1'b0;
    holdoff_req = HoldoffCycles;
    start = samples_sent;
    while (samples_sent - start < 40) run_gesture();
    wait_idle();
  endtask

  task automatic finish_run();
    int unsigned waited;
    in_valid_i = 1'b0;
    stall_on = 1'b0;
    waited = 0;
    while (pending_gestures.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (IdleGap) @(negedge clk_i);
    if (pending_gestures.size() != 0) begin
      $error("%0d expected results never arrived", pending_gestures.size());
      fail_count++;
    end
    $display("Checked %0d results from %0d samples across %0d register writes",
             results_checked, samples_sent, reg_writes);
    $display("Gestures: %0d single, %0d double, %0d long presses (%0d full holds)",
             singles_seen, doubles_seen, longs_seen, full_holds_seen);
    if (fail_count == 0)
      $display("touch_gesture_classifier_unit verification clean");
    else
      $display("touch_gesture_classifier_unit verification failed");
    $finish;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sensor_reading_i = '0;
    now_ms_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgThreshold;
    cfg_data_i = '0;
    cfg_mirror = '{ThresholdRst, TapWindowRst, LongPressRst, FullHoldRst};
    pad_down = 1'b0;
    long_hold = 1'b0;
    press_start_ms = '0;
    last_tap_ms = '0;
    pending_taps = 2'd0;
    clock_ms = '0;
    pace_on = 1'b0;
    stall_on = 1'b0;
    burst_left = 0;
    holdoff_req = 0;
    holdoff_left = 0;
    stall_run = 0;
    stall_phase = 1'b0;
    fail_count = 0;
    samples_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    singles_seen = 0;
    doubles_seen = 0;
    longs_seen = 0;
    full_holds_seen = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_gestures();
    test_time_wrap();
    test_register_extremes();
    test_random_gestures();
    test_output_backpressure();
    finish_run();
  end

endmodule
